@@ hw/rtl/greedy_box_suppressor_macros.svh @@
// ----------------------------------------------------------------------------
// greedy_box_suppressor assertion macros
// Shorthand for clocked implication checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSOR_MACROS_SVH
`define GREEDY_BOX_SUPPRESSOR_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Types, widths and constants shared by the box suppressor.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int COORD_W      = 16;
    localparam int SIZE_W       = 15;
    localparam int AREA_W       = 2 * SIZE_W;
    localparam int UNI_W        = AREA_W + 1;
    localparam int THR_W        = 16;
    localparam int PROD_W       = THR_W + UNI_W;
    localparam int IDX_W        = 16;
    localparam int MAX_KEPT_DEF = 128;

    localparam logic [THR_W-1:0] THR_RESET = 16'd26214;
    localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_box;

    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_entry;

    typedef struct packed {
        logic vld;
        logic hit;
        logic busy;
    } t_cmp_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/gbs_if.sv @@
// ----------------------------------------------------------------------------
// gbs_if
// Valid/ready channels for boxes, results and the threshold register.
// ----------------------------------------------------------------------------
interface gbs_box_if import gbs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      start_of_set;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [SIZE_W-1:0]         box_w;
    logic [SIZE_W-1:0]         box_h;

    modport source (output valid, start_of_set, box_x, box_y, box_w, box_h, input ready);
    modport sink   (input valid, start_of_set, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gbs_result_if import gbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             keep;
    logic [IDX_W-1:0] item_index;
    logic             table_full;

    modport source (output valid, keep, item_index, table_full, input ready);
    modport sink   (input valid, keep, item_index, table_full, output ready);
endinterface

interface gbs_cfg_if import gbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] iou_threshold;

    modport source (output valid, iou_threshold, input ready);
    modport sink   (input valid, iou_threshold, output ready);
endinterface

@@ hw/rtl/gbs_iou_unit.sv @@
// ----------------------------------------------------------------------------
// gbs_iou_unit
// Pipelined overlap test of the current box against one kept box per cycle:
// intersection * 65536 > threshold * union, zero union never hits.
// ----------------------------------------------------------------------------
module gbs_iou_unit import gbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_box              i_cur,
    input  logic [AREA_W-1:0] i_cur_area,
    input  logic [THR_W-1:0]  i_thr,
    input  t_entry            i_kept,
    output t_cmp_stat         o_stat
);

    logic signed [COORD_W-1:0] w_x0, w_y0;
    logic signed [COORD_W:0]   w_cx1, w_kx1, w_cy1, w_ky1, w_x1, w_y1;
    logic signed [COORD_W+1:0] w_dx, w_dy;

    logic                r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;
    logic [SIZE_W-1:0]   r_dx, r_dy;
    logic [AREA_W-1:0]   r_ka_a, r_ka_b;
    logic [AREA_W-1:0]   r_inter_b, r_inter_c, r_inter_d;
    logic [UNI_W-1:0]    r_uni;
    logic [PROD_W-1:0]   r_prod;
    logic                r_nz;
    logic                r_hit;

    always_comb begin
        w_x0  = (i_cur.x > i_kept.box.x) ? i_cur.x : i_kept.box.x;
        w_y0  = (i_cur.y > i_kept.box.y) ? i_cur.y : i_kept.box.y;
        w_cx1 = {i_cur.x[COORD_W-1], i_cur.x} + $signed({2'b00, i_cur.w});
        w_kx1 = {i_kept.box.x[COORD_W-1], i_kept.box.x} + $signed({2'b00, i_kept.box.w});
        w_cy1 = {i_cur.y[COORD_W-1], i_cur.y} + $signed({2'b00, i_cur.h});
        w_ky1 = {i_kept.box.y[COORD_W-1], i_kept.box.y} + $signed({2'b00, i_kept.box.h});
        w_x1  = (w_cx1 < w_kx1) ? w_cx1 : w_kx1;
        w_y1  = (w_cy1 < w_ky1) ? w_cy1 : w_ky1;
        w_dx  = {w_x1[COORD_W], w_x1} - {{2{w_x0[COORD_W-1]}}, w_x0};
        w_dy  = {w_y1[COORD_W], w_y1} - {{2{w_y0[COORD_W-1]}}, w_y0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        // edge overlap, clamp empty to zero
        r_dx      <= (w_dx > 0 && w_dy > 0) ? w_dx[SIZE_W-1:0] : '0;
        r_dy      <= (w_dx > 0 && w_dy > 0) ? w_dy[SIZE_W-1:0] : '0;
        r_ka_a    <= i_kept.area;
        r_inter_b <= {{SIZE_W{1'b0}}, r_dx} * {{SIZE_W{1'b0}}, r_dy};
        r_ka_b    <= r_ka_a;
        r_uni     <= {1'b0, i_cur_area} + {1'b0, r_ka_b} - {1'b0, r_inter_b};
        r_inter_c <= r_inter_b;
        r_prod    <= {{UNI_W{1'b0}}, i_thr} * {{THR_W{1'b0}}, r_uni};
        r_nz      <= (r_uni != '0);
        r_inter_d <= r_inter_c;
        r_hit     <= r_nz && ({1'b0, r_inter_d, {THR_W{1'b0}}} > r_prod);
    end

    assign o_stat.vld  = r_vld_e;
    assign o_stat.hit  = r_hit;
    assign o_stat.busy = r_vld_a | r_vld_b | r_vld_c | r_vld_d | r_vld_e;

endmodule

@@ hw/rtl/greedy_box_suppressor.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppressor
// Greedy non-maximum suppression over score-sorted boxes by an IoU test.
// ----------------------------------------------------------------------------
// Boxes arrive one per word, already sorted by falling score; start_of_set
// empties the kept list and restarts item_index. Each box is checked against
// every stored box through one shared, pipelined overlap unit fed by the
// single read port of the kept-box memory, one stored box per cycle. A box
// holds the input off from its accept through the area, scan, drain and done
// states, and longer only while the result before it still waits on the
// output register; the next box is taken while one result waits there. A
// surviving box is stored while the list has fewer than MAX_KEPT entries,
// otherwise it comes out with keep and table_full set. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`include "greedy_box_suppressor_macros.svh"

module greedy_box_suppressor import gbs_pkg::*; #(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gbs_box_if.sink      i_box,
    gbs_cfg_if.sink      i_cfg,
    gbs_result_if.source o_res
);

    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

    t_state            r_state, n_state;
    t_entry            r_mem [MAX_KEPT];
    t_entry            r_rd_data;
    logic              r_rd_vld;
    t_box              r_cur;
    logic [AREA_W-1:0] r_area;
    logic [THR_W-1:0]  r_thr;
    logic [CNT_W-1:0]  r_cnt, r_idx;
    logic [IDX_W-1:0]  r_item_cnt, r_cur_idx;
    logic              r_keep;
    logic              r_out_vld, r_out_keep, r_out_full;
    logic [IDX_W-1:0]  r_out_idx;

    logic              w_acc, w_rd, w_wr, w_load, w_full;
    logic [IDX_W-1:0]  w_base;
    t_cmp_stat         w_stat;

    assign w_acc  = i_box.valid && i_box.ready;
    assign w_full = (r_cnt == CNT_MAX);
    assign w_base = i_box.start_of_set ? '0 : r_item_cnt;

    assign i_box.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_rd    = 1'b0;
        w_wr    = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_AREA;
                end
            end
            ST_AREA: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == r_cnt) begin
                    n_state = ST_DRAIN;
                end else begin
                    w_rd = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    w_load  = 1'b1;
                    w_wr    = r_keep && !w_full;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_cnt      <= '0;
            r_item_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_keep     <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.iou_threshold;
            end
            r_rd_vld <= w_rd;
            if (w_acc) begin
                r_keep     <= 1'b1;
                r_idx      <= '0;
                r_item_cnt <= (w_base == IDX_MAX) ? w_base : w_base + 1'b1;
                if (i_box.start_of_set) begin
                    r_cnt <= '0;
                end
            end else begin
                if (w_rd) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (w_stat.vld && w_stat.hit) begin
                    r_keep <= 1'b0;
                end
                if (w_wr) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cur.x   <= i_box.box_x;
            r_cur.y   <= i_box.box_y;
            r_cur.w   <= i_box.box_w;
            r_cur.h   <= i_box.box_h;
            r_cur_idx <= w_base;
        end
        if (r_state == ST_AREA) begin
            r_area <= {{SIZE_W{1'b0}}, r_cur.w} * {{SIZE_W{1'b0}}, r_cur.h};
        end
        if (w_load) begin
            r_out_keep <= r_keep;
            r_out_full <= r_keep && w_full;
            r_out_idx  <= r_cur_idx;
        end
    end

    // kept-box store
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= '{box: r_cur, area: r_area};
        end
        if (w_rd) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    gbs_iou_unit u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_rd_vld),
        .i_cur      (r_cur),
        .i_cur_area (r_area),
        .i_thr      (r_thr),
        .i_kept     (r_rd_data),
        .o_stat     (w_stat)
    );

    assign o_res.valid      = r_out_vld;
    assign o_res.keep       = r_out_keep;
    assign o_res.item_index = r_out_idx;
    assign o_res.table_full = r_out_full;

    `GBS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_MAX, "kept count overflow")
    `GBS_ASSERT_IMP(a_cmp_window, i_clk, i_rst_n, w_stat.vld, r_state == ST_SCAN || r_state == ST_DRAIN, "compare result outside scan")
    `GBS_ASSERT_IMP(a_wr_room, i_clk, i_rst_n, w_wr, r_cnt < CNT_MAX, "store write while full")
    `GBS_ASSERT_IMP(a_full_keep, i_clk, i_rst_n, o_res.valid && o_res.table_full, o_res.keep, "full flag on suppressed box")
    `GBS_ASSERT_NXT(a_done_load, i_clk, i_rst_n, w_load, o_res.valid, "result not presented")

endmodule
